// ===== rtl/mctt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mctt_pkg
// Types, codes and constants shared by the tick timer bank modules.
// ============================================================================
package mctt_pkg;

  localparam int TIMERS_DEF  = 8;
  localparam int ID_EXT_W    = 7;
  localparam int MAX_REPORTS = 8;
  localparam int CNT_W       = 4;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_ADD    = 3'd2;
  localparam logic [2:0] OP_STOP   = 3'd3;
  localparam logic [2:0] OP_STATUS = 3'd4;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  timer_id;
    logic        periodic;
    logic        notify;
    logic [30:0] period;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] which_timer;
    logic       running;
    logic       last;
  } out_item_t;

  // The remaining count is a two's complement value; zero or below means stopped.
  typedef struct packed {
    logic [31:0] remaining;
    logic [30:0] reload_value;
    logic        repeat_mode;
    logic        report_enable;
  } entry_t;

  typedef struct packed {
    logic [31:0] value;
    logic        le_zero;
  } alu_res_t;

endpackage
`default_nettype wire

// ===== rtl/mctt_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mctt_bank
// Timer entry storage with one write port, one registered read port and a
// valid bit per entry so that unwritten entries read as all zero.
// ============================================================================
module mctt_bank #(
  parameter int TIMERS = mctt_pkg::TIMERS_DEF,
  parameter int AW     = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire mctt_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output mctt_pkg::entry_t     rd_data
);
  import mctt_pkg::*;

  entry_t            mem [TIMERS];
  entry_t            rd_data_r;
  logic [TIMERS-1:0] vld_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule
`default_nettype wire

// ===== rtl/mctt_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mctt_alu
// Shared add/subtract unit with saturation at the largest positive count and
// a flag for results of zero or below.
// ============================================================================
module mctt_alu (
  input  wire logic        sub,
  input  wire logic [31:0] a,
  input  wire logic [32:0] b,
  output mctt_pkg::alu_res_t res
);
  import mctt_pkg::*;

  logic [32:0] a_ext;
  logic [32:0] sum;
  logic        sat;

  assign a_ext = {a[31], a};
  assign sum   = sub ? (a_ext - b) : (a_ext + b);
  assign sat   = !sum[32] && sum[31];

  assign res.value   = sat ? SAT_MAX : sum[31:0];
  assign res.le_zero = sum[32] || (sum == '0);

endmodule
`default_nettype wire

// ===== rtl/multi_channel_tick_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// multi_channel_tick_timer
// Bank of countdown timers driven by tick, start, add, stop and status
// transactions, with expiry and status results.
// ============================================================================
// A tick transaction walks the timer entries through one shared adder, one
// entry per cycle except while the result channel stalls a pending result;
// add runs the count and the reload value through the same adder one after
// the other. Expiry results of a tick come out in ascending timer order, at
// most eight per tick, and the last result of a transaction carries last.
// The step register may only be written while the block is idle.
module multi_channel_tick_timer #(
  parameter int TIMERS = mctt_pkg::TIMERS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire mctt_pkg::in_item_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mctt_pkg::out_item_t out_data,
  input  wire logic          cfg_wr_en,
  input  wire logic [15:0]   cfg_wr_data
);
  import mctt_pkg::*;

  localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TICK  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_STOP  = 3'd4;
  localparam logic [2:0] S_ADD_C = 3'd5;
  localparam logic [2:0] S_ADD_R = 3'd6;
  localparam logic [2:0] S_STAT  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  out_item_t        pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  in_item_t         item_r, item_nxt;
  logic             id_ok_r, id_ok_nxt;
  logic [31:0]      sum_r, sum_nxt;
  logic [15:0]      tick_step_r;

  logic [ID_EXT_W-1:0] in_id_ext;
  logic [ID_EXT_W-1:0] id_ext;
  logic [ID_EXT_W-1:0] idx_ext;
  logic                in_ok;
  logic [AW-1:0]       in_addr;
  logic [AW-1:0]       id_addr;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        ent;

  logic        alu_sub;
  logic [31:0] alu_a;
  logic [32:0] alu_b;
  alu_res_t    alu_res;

  logic ent_running;
  logic expired;
  logic report;
  logic need_push;
  logic out_free;
  logic idx_last;

  assign in_id_ext = ID_EXT_W'(in_data.timer_id);
  assign in_ok     = in_id_ext < ID_EXT_W'(TIMERS);
  assign in_addr   = in_id_ext[AW-1:0];
  assign id_ext    = ID_EXT_W'(item_r.timer_id);
  assign id_addr   = id_ext[AW-1:0];
  assign idx_ext   = ID_EXT_W'(idx_r);
  assign idx_last  = idx_r == AW'(TIMERS - 1);

  assign ent_running = !ent.remaining[31] && (ent.remaining != '0);
  assign expired     = ent_running && alu_res.le_zero;
  assign report      = expired && ent.report_enable && (n_r < CNT_W'(MAX_REPORTS));
  assign need_push   = report && pend_vld_r;
  assign out_free    = !out_valid_r || !out_stall;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mctt_bank #(
    .TIMERS (TIMERS),
    .AW     (AW)
  ) u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ent)
  );

  mctt_alu u_alu (
    .sub (alu_sub),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    item_nxt      = item_r;
    id_ok_nxt     = id_ok_r;
    sum_nxt       = sum_r;
    wr_en         = 1'b0;
    wr_addr       = id_addr;
    wr_data       = ent;
    rd_en         = 1'b0;
    rd_addr       = in_addr;
    alu_sub       = 1'b0;
    alu_a         = ent.remaining;
    alu_b         = {2'b00, item_r.period};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt     = in_data;
          id_ok_nxt    = in_ok;
          n_nxt        = '0;
          pend_vld_nxt = 1'b0;
          idx_nxt      = '0;
          unique case (in_data.op)
            OP_TICK: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_TICK;
            end
            OP_START: begin
              if (in_ok) begin
                state_nxt = S_START;
              end
            end
            OP_ADD: begin
              if (in_ok) begin
                rd_en     = 1'b1;
                state_nxt = S_ADD_C;
              end
            end
            OP_STOP: begin
              if (in_ok) begin
                rd_en     = 1'b1;
                state_nxt = S_STOP;
              end
            end
            OP_STATUS: begin
              rd_en     = in_ok;
              state_nxt = S_STAT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_TICK: begin
        alu_sub = 1'b1;
        alu_b   = {17'd0, tick_step_r};
        if (!need_push || out_free) begin
          if (ent_running) begin
            wr_en   = 1'b1;
            wr_addr = idx_r;
            wr_data = ent;
            if (expired && ent.repeat_mode) begin
              wr_data.remaining = {1'b0, ent.reload_value};
            end else begin
              wr_data.remaining = alu_res.value;
            end
          end
          if (need_push) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = pend_r;
          end
          if (report) begin
            pend_vld_nxt         = 1'b1;
            pend_nxt.kind        = KIND_EXPIRY;
            pend_nxt.which_timer = idx_ext[2:0];
            pend_nxt.running     = 1'b0;
            pend_nxt.last        = 1'b0;
            n_nxt                = n_r + 1'b1;
          end
          if (idx_last) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = pend_r;
          out_data_nxt.last = 1'b1;
          pend_vld_nxt      = 1'b0;
          state_nxt         = S_IDLE;
        end
      end
      S_START: begin
        wr_en = 1'b1;
        if (item_r.period == '0) begin
          wr_data = '0;
        end else begin
          wr_data.remaining     = {1'b0, item_r.period};
          wr_data.reload_value  = item_r.period;
          wr_data.repeat_mode   = item_r.periodic;
          wr_data.report_enable = item_r.notify;
        end
        state_nxt = S_IDLE;
      end
      S_STOP: begin
        wr_en                 = 1'b1;
        wr_data               = ent;
        wr_data.remaining     = '0;
        wr_data.repeat_mode   = 1'b0;
        wr_data.report_enable = 1'b0;
        state_nxt             = S_IDLE;
      end
      S_ADD_C: begin
        sum_nxt   = alu_res.value;
        state_nxt = S_ADD_R;
      end
      S_ADD_R: begin
        alu_a                = {1'b0, ent.reload_value};
        wr_en                = 1'b1;
        wr_data              = ent;
        wr_data.remaining    = sum_r;
        wr_data.reload_value = alu_res.value[30:0];
        state_nxt            = S_IDLE;
      end
      S_STAT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = KIND_STATUS;
          out_data_nxt.which_timer = item_r.timer_id;
          out_data_nxt.running     = id_ok_r && ent_running;
          out_data_nxt.last        = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      n_r         <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tick_step_r <= 16'd1;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        tick_step_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
    item_r     <= item_nxt;
    id_ok_r    <= id_ok_nxt;
    sum_r      <= sum_nxt;
  end

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == KIND_STATUS) |-> out_data_r.last)
    else $error("status result without last");

  a_report_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_REPORTS))
    else $error("expiry report count above limit");

  a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (state_r == S_TICK || state_r == S_FLUSH))
    else $error("pending expiry outside a tick walk");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r != S_IDLE)
    else $error("entry write while idle");

  a_push_frees_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && pend_vld_r && out_free) |=> (out_valid_r && out_data_r.last))
    else $error("final tick result not delivered with last");

endmodule
`default_nettype wire

// ===== verif/multi_channel_tick_timer_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// multi_channel_tick_timer_tb
// Self-checking testbench for the tick timer bank. A directed table covers
// reset state, expiry limits, saturation, stop and negative counts. Random
// phases with different tick steps follow. Every accepted transaction runs
// through a behavioral model of the bank, and each result is compared with
// the oldest expected result.
// ============================================================================
module multi_channel_tick_timer_tb;
  import mctt_pkg::*;

  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          PHASE_ITEMS   = 70;
  localparam int          PHASES        = 6;
  localparam int          HOLD_LEN      = 400;
  localparam int          IDLE_SETTLE   = TIMERS_DEF + 6;
  localparam int          DRAIN_CYCLES  = 4 * TIMERS_DEF + 20;
  localparam int          MAX_PRINTS    = 50;
  localparam logic [2:0]  OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  OP_RSVD_LAST  = 3'd7;
  localparam logic [30:0] PERIOD_MAX    = SAT_MAX[30:0];
  localparam longint      COUNT_MAX     = 64'sd2147483647;

  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_NONE,
    ROW_ONE,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t   rk;
    in_item_t    item;
    logic        run;
    logic [15:0] step;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  logic signed [31:0] tmr_remain [TIMERS_DEF];
  logic [30:0]        tmr_reload [TIMERS_DEF];
  logic               tmr_repeat [TIMERS_DEF];
  logic               tmr_notify [TIMERS_DEF];
  logic [15:0]        step_val;

  out_item_t step_results [$];
  out_item_t expected_results [$];
  dir_row_t  dir_tab [$];

  int err_count   = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  int hold_left   = 0;
  bit hold_req    = 1'b0;
  bit quiet       = 1'b0;

  multi_channel_tick_timer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    err_count = err_count + 1;
    if (err_count <= MAX_PRINTS) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Behavioral model of one transaction; fills step_results.
  task automatic timer_bank_step(input in_item_t it);
    longint    c;
    longint    r;
    out_item_t o;
    int        id;
    step_results.delete();
    id = it.timer_id;
    case (it.op)
      OP_TICK: begin
        for (int i = 0; i < TIMERS_DEF; i++) begin
          if (tmr_remain[i] > 0) begin
            c = longint'(tmr_remain[i]) - longint'(step_val);
            tmr_remain[i] = c[31:0];
            if (c <= 0) begin
              if (tmr_notify[i] && step_results.size() < MAX_REPORTS) begin
                o.kind        = KIND_EXPIRY;
                o.which_timer = i[2:0];
                o.running     = 1'b0;
                o.last        = 1'b0;
                step_results.push_back(o);
              end
              if (tmr_repeat[i]) begin
                tmr_remain[i] = {1'b0, tmr_reload[i]};
              end
            end
          end
        end
      end
      OP_START: begin
        if (it.period == '0) begin
          tmr_remain[id] = '0;
          tmr_reload[id] = '0;
          tmr_repeat[id] = 1'b0;
          tmr_notify[id] = 1'b0;
        end else begin
          tmr_remain[id] = {1'b0, it.period};
          tmr_reload[id] = it.period;
          tmr_repeat[id] = it.periodic;
          tmr_notify[id] = it.notify;
        end
      end
      OP_ADD: begin
        c = longint'(tmr_remain[id]) + longint'(it.period);
        r = longint'(tmr_reload[id]) + longint'(it.period);
        if (c > COUNT_MAX) c = COUNT_MAX;
        if (r > COUNT_MAX) r = COUNT_MAX;
        tmr_remain[id] = c[31:0];
        tmr_reload[id] = r[30:0];
      end
      OP_STOP: begin
        tmr_remain[id] = '0;
        tmr_repeat[id] = 1'b0;
        tmr_notify[id] = 1'b0;
      end
      OP_STATUS: begin
        o.kind        = KIND_STATUS;
        o.which_timer = it.timer_id;
        o.running     = (tmr_remain[id] > 0);
        o.last        = 1'b0;
        step_results.push_back(o);
      end
      default: ;
    endcase
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].last = 1'b1;
    end
  endtask

  function automatic logic [30:0] rand_period();
    int r;
    int lim;
    r   = $urandom_range(0, 99);
    lim = 4 * int'(step_val) + 4;
    if (r < 10) begin
      return '0;
    end else if (r < 60) begin
      return 31'($urandom_range(1, lim));
    end else if (r < 80) begin
      return 31'($urandom);
    end
    return 31'(PERIOD_MAX - $urandom_range(0, 200));
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      it.op = OP_TICK;
    end else if (r < 60) begin
      it.op = OP_START;
    end else if (r < 70) begin
      it.op = OP_ADD;
    end else if (r < 78) begin
      it.op = OP_STOP;
    end else if (r < 95) begin
      it.op = OP_STATUS;
    end else begin
      it.op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    end
    it.timer_id = 3'($urandom_range(0, TIMERS_DEF - 1));
    it.periodic = 1'($urandom_range(0, 1));
    it.notify   = 1'($urandom_range(0, 1));
    it.period   = rand_period();
    return it;
  endfunction

  function automatic dir_row_t dir_row(input row_kind_t rk, input logic [2:0] op,
                                       input logic [2:0] id, input logic per,
                                       input logic ntf, input logic [30:0] prd,
                                       input logic run);
    dir_row_t d;
    d.rk            = rk;
    d.item.op       = op;
    d.item.timer_id = id;
    d.item.periodic = per;
    d.item.notify   = ntf;
    d.item.period   = prd;
    d.run           = run;
    d.step          = prd[15:0];
    return d;
  endfunction

  task automatic send_item(input in_item_t it, input row_kind_t rk, input logic run);
    int        gap;
    out_item_t ans;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    timer_bank_step(it);
    case (rk)
      ROW_PRED: begin
        foreach (step_results[k]) expected_results.push_back(step_results[k]);
      end
      ROW_ONE: begin
        ans.kind        = KIND_STATUS;
        ans.which_timer = it.timer_id;
        ans.running     = run;
        ans.last        = 1'b1;
        expected_results.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // The step register may only change while the bank is idle.
  task automatic set_step(input logic [15:0] value);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    step_val = value;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = expected_results.pop_front();
    if (got.kind !== want.kind) begin
      report_mismatch($sformatf("kind %b, expected %b", got.kind, want.kind));
    end
    if (got.which_timer !== want.which_timer) begin
      report_mismatch($sformatf("which_timer %0d, expected %0d",
                                got.which_timer, want.which_timer));
    end
    if (got.running !== want.running) begin
      report_mismatch($sformatf("running %b, expected %b", got.running, want.running));
    end
    if (got.last !== want.last) begin
      report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        check_result(out_data);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0 && !quiet) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        stall_left = gap_len();
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    in_item_t    it;
    logic [15:0] phase_step;
    int          n_items;

    for (int i = 0; i < TIMERS_DEF; i++) begin
      tmr_remain[i] = '0;
      tmr_reload[i] = '0;
      tmr_repeat[i] = 1'b0;
      tmr_notify[i] = 1'b0;
    end
    step_val = 16'd1;

    dir_tab.push_back(dir_row(ROW_ONE,  OP_STATUS, 3'd5, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_TICK,   3'd0, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_START,  3'd0, 1'b1, 1'b1, 31'd1, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_START,  3'd1, 1'b0, 1'b1, 31'd2, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_START,  3'd2, 1'b1, 1'b1, 31'd1, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_START,  3'd3, 1'b1, 1'b1, 31'd1, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_START,  3'd4, 1'b1, 1'b1, 31'd1, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_START,  3'd5, 1'b1, 1'b1, 31'd1, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_START,  3'd6, 1'b1, 1'b1, 31'd1, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_START,  3'd7, 1'b1, 1'b1, 31'd2, 1'b0));
    dir_tab.push_back(dir_row(ROW_PRED, OP_TICK,   3'd0, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_PRED, OP_TICK,   3'd0, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_ONE,  OP_STATUS, 3'd1, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_START,  3'd2, 1'b1, 1'b1, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_ONE,  OP_STATUS, 3'd2, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_STOP,   3'd0, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_ONE,  OP_STATUS, 3'd0, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_ADD,    3'd4, 1'b0, 1'b0, PERIOD_MAX, 1'b0));
    dir_tab.push_back(dir_row(ROW_ONE,  OP_STATUS, 3'd4, 1'b0, 1'b0, 31'd0, 1'b1));
    dir_tab.push_back(dir_row(ROW_NONE, OP_RSVD_LAST, 3'd7, 1'b1, 1'b1, PERIOD_MAX, 1'b0));
    dir_tab.push_back(dir_row(ROW_CFG,  OP_TICK,   3'd0, 1'b0, 1'b0, 31'd65535, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_START,  3'd1, 1'b0, 1'b1, 31'd5, 1'b0));
    dir_tab.push_back(dir_row(ROW_PRED, OP_TICK,   3'd0, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_ONE,  OP_STATUS, 3'd1, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_ADD,    3'd1, 1'b0, 1'b0, 31'd7, 1'b0));
    dir_tab.push_back(dir_row(ROW_ONE,  OP_STATUS, 3'd1, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_CFG,  OP_TICK,   3'd0, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_NONE, OP_TICK,   3'd0, 1'b0, 1'b0, 31'd0, 1'b0));
    dir_tab.push_back(dir_row(ROW_ONE,  OP_STATUS, 3'd4, 1'b0, 1'b0, 31'd0, 1'b1));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].rk == ROW_CFG) begin
        set_step(dir_tab[k].step);
      end else begin
        send_item(dir_tab[k].item, dir_tab[k].rk, dir_tab[k].run);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       phase_step = 16'd1;
        1:       phase_step = 16'd65535;
        2:       phase_step = 16'd2;
        3:       phase_step = 16'($urandom_range(1, 65535));
        4:       phase_step = 16'd1;
        default: phase_step = 16'd16;
      endcase
      set_step(phase_step);
      quiet = (ph == 4);
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        it = rand_item();
        send_item(it, ROW_PRED, 1'b0);
        if (it.op <= OP_STATUS) begin
          n_items = n_items + 1;
        end
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
